[design/tiep_pkg.sv]
package tiep_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_BIG_ENDIAN       = 2'd0;
   localparam logic [1:0] CSR_DIRECTORY_OFFSET = 2'd1;
   localparam logic [1:0] CSR_FILE_LENGTH      = 2'd2;

   localparam logic [31:0] DIRECTORY_OFFSET_RESET = 32'd8;

   // byte positions inside the header and one entry
   localparam logic [3:0] ENTRY_BYTES  = 4'd12;
   localparam logic [3:0] PH_TYPE      = 4'd2;
   localparam logic [3:0] PH_COUNT     = 4'd4;
   localparam logic [3:0] PH_VALUE     = 4'd8;
   localparam logic [3:0] PH_LAST      = 4'd11;
   localparam logic [33:0] COUNT_BYTES = 34'd2;
   localparam logic [33:0] ENTRY_SPAN  = 34'd12;
   localparam logic [34:0] INLINE_LIMIT = 35'd4;

   // field type codes that are not one byte wide
   localparam logic [15:0] TT_SHORT     = 16'd3;
   localparam logic [15:0] TT_LONG      = 16'd4;
   localparam logic [15:0] TT_RATIONAL  = 16'd5;
   localparam logic [15:0] TT_SSHORT    = 16'd8;
   localparam logic [15:0] TT_SLONG     = 16'd9;
   localparam logic [15:0] TT_SRATIONAL = 16'd10;
   localparam logic [15:0] TT_FLOAT     = 16'd11;
   localparam logic [15:0] TT_DOUBLE    = 16'd12;

   typedef struct packed {
      logic        big_endian;
      logic [31:0] directory_offset;
      logic [31:0] file_length;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] tag_id;
      logic [15:0] type_code;
      logic [31:0] element_count;
      logic [3:0]  element_size;
      logic [34:0] data_size;
      logic        is_inline;
      logic [31:0] value_word;
      logic        data_present;
      logic        last;
      logic        truncated;
   } rsp_type;

endpackage

[design/tiep_channels.sv]
interface tiep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_req;

   modport source (output valid, data_byte, start_req, input ready);
   modport sink   (input valid, data_byte, start_req, output ready);
endinterface

interface tiep_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] tag_id;
   logic [15:0] type_code;
   logic [31:0] element_count;
   logic [3:0]  element_size;
   logic [34:0] data_size;
   logic        is_inline;
   logic [31:0] value_word;
   logic        data_present;
   logic        last;
   logic        truncated;

   modport source (output valid, kind, tag_id, type_code, element_count, element_size,
                   data_size, is_inline, value_word, data_present, last, truncated,
                   input ready);
   modport sink   (input valid, kind, tag_id, type_code, element_count, element_size,
                   data_size, is_inline, value_word, data_present, last, truncated,
                   output ready);
endinterface

[design/tiep_entry_eval.sv]
module tiep_entry_eval (
   input  logic [15:0] type_code,
   input  logic [31:0] element_count,
   input  logic [31:0] value_word,
   input  logic [31:0] file_length,
   output logic [3:0]  element_size,
   output logic [34:0] data_size,
   output logic        is_inline,
   output logic        data_present
);
   import tiep_pkg::*;

   logic [35:0] end_offset;

   // element size is a power of two, so the size product is a shift
   always_comb begin
      unique case (type_code)
         TT_SHORT, TT_SSHORT: begin
            element_size = 4'd2;
            data_size    = {2'b0, element_count, 1'b0};
         end
         TT_LONG, TT_SLONG, TT_FLOAT: begin
            element_size = 4'd4;
            data_size    = {1'b0, element_count, 2'b0};
         end
         TT_RATIONAL, TT_SRATIONAL, TT_DOUBLE: begin
            element_size = 4'd8;
            data_size    = {element_count, 3'b0};
         end
         default: begin
            element_size = 4'd1;
            data_size    = {3'b0, element_count};
         end
      endcase
   end

   assign is_inline    = (data_size <= INLINE_LIMIT);
   assign end_offset   = {4'b0, value_word} + {1'b0, data_size};
   assign data_present = is_inline || (end_offset <= {4'b0, file_length});

endmodule

[design/tiep_parser.sv]
module tiep_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic [7:0]       data_byte,
   input  logic             start_req,
   input  tiep_pkg::cfg_type cfg,
   output logic             res_valid,
   output tiep_pkg::rsp_type res
);
   import tiep_pkg::*;

   logic [32:0] pos_ff, pos_in;
   logic [3:0]  phase_ff, phase_in;
   logic        hdr_done_ff, hdr_done_in;
   logic [15:0] entries_ff, entries_in;
   logic        active_ff, active_in;
   logic [15:0] tag_ff, tag_in;
   logic [15:0] type_ff, type_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] value_ff, value_in;

   logic        eff_active;
   logic        eff_hdr_done;
   logic [3:0]  eff_phase;
   logic [32:0] eff_pos;
   logic [15:0] eff_entries;
   logic [32:0] hdr_pos;
   logic [32:0] ent_pos;
   logic        count_fail;
   logic        hdr_fail;
   logic        ent_fail;
   logic [3:0]  k;
   logic [31:0] value_byte;
   logic [3:0]  ev_size;
   logic [34:0] ev_dsize;
   logic        ev_inline;
   logic        ev_present;

   function automatic logic [15:0] put16(input logic [15:0] acc, input logic [7:0] b,
                                         input logic k1, input logic big);
      logic [15:0] r;
      if (!k1) r = {8'h00, b};
      else if (big) r = {acc[7:0], b};
      else r = acc | {b, 8'h00};
      return r;
   endfunction

   function automatic logic [31:0] put32(input logic [31:0] acc, input logic [7:0] b,
                                         input logic [1:0] k2, input logic big);
      logic [31:0] r;
      if (k2 == 2'd0) r = {24'h0, b};
      else if (big) r = {acc[23:0], b};
      else r = acc | ({24'h0, b} << {k2, 3'b000});
      return r;
   endfunction

   // a start byte restarts the parse and is itself the first count byte
   assign eff_active   = start_req || active_ff;
   assign eff_hdr_done = !start_req && hdr_done_ff;
   assign eff_phase    = start_req ? 4'd0 : phase_ff;
   assign eff_pos      = start_req ? {1'b0, cfg.directory_offset} : pos_ff;
   assign eff_entries  = start_req ? 16'd0 : entries_ff;

   assign hdr_pos    = eff_pos + 33'd2;
   assign ent_pos    = pos_ff + 33'd12;
   assign count_fail = ({2'b0, cfg.directory_offset} + COUNT_BYTES) > {2'b0, cfg.file_length};
   assign hdr_fail   = ({1'b0, hdr_pos} + ENTRY_SPAN) > {2'b0, cfg.file_length};
   assign ent_fail   = ({1'b0, ent_pos} + ENTRY_SPAN) > {2'b0, cfg.file_length};

   assign k          = (phase_ff >= ENTRY_BYTES) ? 4'd0 : phase_ff;
   assign value_byte = put32(value_ff, data_byte, k[1:0], cfg.big_endian);

   tiep_entry_eval u_eval (
      .type_code     (type_ff),
      .element_count (count_ff),
      .value_word    (value_byte),
      .file_length   (cfg.file_length),
      .element_size  (ev_size),
      .data_size     (ev_dsize),
      .is_inline     (ev_inline),
      .data_present  (ev_present)
   );

   always_comb begin
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      hdr_done_in = hdr_done_ff;
      entries_in  = entries_ff;
      active_in   = active_ff;
      tag_in      = tag_ff;
      type_in     = type_ff;
      count_in    = count_ff;
      value_in    = value_ff;
      res_valid   = 1'b0;
      res              = '0;
      res.kind         = 1'b1;
      res.element_size = 4'd1;
      res.last         = 1'b1;

      if (fire) begin
         if (start_req) begin
            active_in   = 1'b1;
            hdr_done_in = 1'b0;
            phase_in    = 4'd0;
            entries_in  = 16'd0;
            tag_in      = 16'd0;
            type_in     = 16'd0;
            count_in    = 32'd0;
            value_in    = 32'd0;
            pos_in      = {1'b0, cfg.directory_offset};
         end
         if (start_req && count_fail) begin
            // count itself runs past the end of the file
            res_valid     = 1'b1;
            res.truncated = 1'b1;
            active_in     = 1'b0;
         end else if (eff_active) begin
            if (!eff_hdr_done) begin
               entries_in = put16(eff_entries, data_byte, eff_phase[0], cfg.big_endian);
               if (!eff_phase[0]) begin
                  phase_in = 4'd1;
               end else begin
                  hdr_done_in = 1'b1;
                  phase_in    = 4'd0;
                  pos_in      = hdr_pos;
                  if (entries_in == 16'd0) begin
                     res_valid = 1'b1;
                     active_in = 1'b0;
                  end else if (hdr_fail) begin
                     res_valid     = 1'b1;
                     res.truncated = 1'b1;
                     active_in     = 1'b0;
                  end
               end
            end else begin
               if (k < PH_TYPE) begin
                  tag_in = put16(tag_ff, data_byte, k[0], cfg.big_endian);
               end else if (k < PH_COUNT) begin
                  type_in = put16(type_ff, data_byte, k[0], cfg.big_endian);
               end else if (k < PH_VALUE) begin
                  count_in = put32(count_ff, data_byte, k[1:0], cfg.big_endian);
               end else begin
                  value_in = value_byte;
               end
               phase_in = k + 4'd1;
               if (k == PH_LAST) begin
                  phase_in          = 4'd0;
                  entries_in        = entries_ff - 16'd1;
                  pos_in            = ent_pos;
                  res_valid         = 1'b1;
                  res.kind          = 1'b0;
                  res.tag_id        = tag_ff;
                  res.type_code     = type_ff;
                  res.element_count = count_ff;
                  res.element_size  = ev_size;
                  res.data_size     = ev_dsize;
                  res.is_inline     = ev_inline;
                  res.value_word    = value_byte;
                  res.data_present  = ev_present;
                  res.last          = 1'b0;
                  if (entries_in == 16'd0) begin
                     res.last = 1'b1;
                  end else if (ent_fail) begin
                     res.last      = 1'b1;
                     res.truncated = 1'b1;
                  end
                  if (res.last) begin
                     active_in = 1'b0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         phase_ff    <= '0;
         hdr_done_ff <= 1'b0;
         entries_ff  <= '0;
         active_ff   <= 1'b0;
         tag_ff      <= '0;
         type_ff     <= '0;
         count_ff    <= '0;
         value_ff    <= '0;
      end else begin
         pos_ff      <= pos_in;
         phase_ff    <= phase_in;
         hdr_done_ff <= hdr_done_in;
         entries_ff  <= entries_in;
         active_ff   <= active_in;
         tag_ff      <= tag_in;
         type_ff     <= type_in;
         count_ff    <= count_in;
         value_ff    <= value_in;
      end
   end

endmodule

[design/tiff_ifd_entry_parser_unit.sv]
// TIFF directory entry parser. Feed the directory one byte per request, with
// start_req set on its first byte (file offset directory_offset). The first two
// bytes are the entry count; then every 12th byte of an entry produces one
// result carrying tag, type, count, element size, exact 35-bit data size, the
// inline flag, the value word and a bounds check against file_length. A
// directory that is empty or whose count or first entry runs past the file end
// gives a single kind 1 result. Throughput is one byte per clock with no gaps
// while the result side does not stall: a byte is captured in the input register,
// then goes through the parse state, and its result is written to the output register,
// from which it is offered. Only a stall on the result side holds off
// requests, and only once both registers are full. Registers are written
// through csr_we/csr_index/csr_wdata and must be changed only while idle.
module tiff_ifd_entry_parser_unit (
   input  logic        clock,
   input  logic        reset,
   tiep_req_if.sink    req_chan,
   tiep_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import tiep_pkg::*;

   cfg_type     cfg_ff, cfg_in;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_start_ff, in_start_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        advance;
   logic        fire;
   logic        res_valid;
   rsp_type     res;

   // configuration writes, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BIG_ENDIAN:       cfg_in.big_endian       = csr_wdata[0];
            CSR_DIRECTORY_OFFSET: cfg_in.directory_offset = csr_wdata;
            CSR_FILE_LENGTH:      cfg_in.file_length      = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // the pipe moves whenever the output slot is empty or being drained
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_start_in = in_start_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.data_byte;
         in_start_in = req_chan.start_req;
      end
   end

   tiep_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (in_byte_ff),
      .start_req (in_start_ff),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // bytes that complete no result just drop out of the output slot
   assign rsp_valid_in = advance ? (fire && res_valid) : rsp_valid_ff;
   assign rsp_in       = advance ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.big_endian       <= 1'b0;
         cfg_ff.directory_offset <= DIRECTORY_OFFSET_RESET;
         cfg_ff.file_length      <= 32'd0;
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_start_ff <= in_start_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_ff.kind;
   assign rsp_chan.tag_id        = rsp_ff.tag_id;
   assign rsp_chan.type_code     = rsp_ff.type_code;
   assign rsp_chan.element_count = rsp_ff.element_count;
   assign rsp_chan.element_size  = rsp_ff.element_size;
   assign rsp_chan.data_size     = rsp_ff.data_size;
   assign rsp_chan.is_inline     = rsp_ff.is_inline;
   assign rsp_chan.value_word    = rsp_ff.value_word;
   assign rsp_chan.data_present  = rsp_ff.data_present;
   assign rsp_chan.last          = rsp_ff.last;
   assign rsp_chan.truncated     = rsp_ff.truncated;

   // requests are held off only when both stages are full and stalled
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (in_valid_ff && rsp_valid_ff && !rsp_chan.ready))
      else $error("request side blocked without a full stalled pipe");

   // a kind 1 result (empty directory or truncated count or header) always closes the directory
   a_kind_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind) |-> rsp_ff.last)
      else $error("kind 1 result without last");

   a_trunc_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.truncated) |-> rsp_ff.last)
      else $error("truncated result without last");

   a_size_pow2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot(rsp_ff.element_size))
      else $error("element size not a power of two");

   a_inline_present: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.is_inline && !rsp_ff.kind) |-> rsp_ff.data_present)
      else $error("inline entry flagged as absent");

endmodule
